[rtl/core/smdr_pkg.sv]
// ----------------------------------------------------------------------------
// smdr_pkg
// Shared constants, widths and types for the median and decile ratio block.
// ----------------------------------------------------------------------------
package smdr_pkg;

  localparam int MAX_ITEMS   = 256;
  localparam int ADDR_W      = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
  localparam int CNT_W       = $clog2(MAX_ITEMS + 1);

  localparam int VALUE_W     = 31;
  localparam int RATIO_W     = 40;
  localparam int COUNT_W     = 9;

  localparam int DEC_MAX     = MAX_ITEMS / 10;
  localparam int SUM_W       = VALUE_W + $clog2(DEC_MAX + 1);
  localparam int DIV_CNT_W   = $clog2(SUM_W + 1);

  // floor(n / 10) as (n * 52429) >> 19, exact for n below 43699
  localparam int DIV10_MUL   = 52429;
  localparam int DIV10_SHIFT = 19;
  localparam int PROD_W      = CNT_W + 16;

  localparam int IN_TDATA_W  = ((VALUE_W + 7) / 8) * 8;
  localparam int OUT_FIELD_W = VALUE_W + RATIO_W + COUNT_W;
  localparam int OUT_TDATA_W = ((OUT_FIELD_W + 7) / 8) * 8;
  localparam int OUT_TUSER_W = 2;

  typedef enum logic [2:0] {
    S_IDLE,
    S_INS,
    S_MED,
    S_MEDW,
    S_SUM,
    S_DIV,
    S_DIVW,
    S_DONE
  } state_e;

endpackage

[rtl/core/smdr_ram.sv]
// ----------------------------------------------------------------------------
// smdr_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
module smdr_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                                   clk_i,
  input  logic                                   we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                       wdata_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                       rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/core/smdr_div.sv]
// ----------------------------------------------------------------------------
// smdr_div
// Restoring divider: one quotient bit per cycle through a shared subtractor.
// ----------------------------------------------------------------------------
module smdr_div (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [smdr_pkg::SUM_W-1:0] dividend_i,
  input  logic [smdr_pkg::SUM_W-1:0] divisor_i,
  output logic                      done_o,
  output logic [smdr_pkg::SUM_W-1:0] quotient_o
);

  localparam int W = smdr_pkg::SUM_W;

  logic                             busy_q, busy_d;
  logic                             done_q, done_d;
  logic [smdr_pkg::DIV_CNT_W-1:0]   cnt_q, cnt_d;
  logic [W-1:0]                     rem_q, rem_d;
  logic [W-1:0]                     quo_q, quo_d;
  logic [W-1:0]                     dsr_q, dsr_d;
  logic [W:0]                       shifted;
  logic [W:0]                       diff;

  always_comb begin
    busy_d  = busy_q;
    done_d  = 1'b0;
    cnt_d   = cnt_q;
    rem_d   = rem_q;
    quo_d   = quo_q;
    dsr_d   = dsr_q;
    shifted = {rem_q, quo_q[W-1]};
    diff    = shifted - {1'b0, dsr_q};
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      rem_d  = '0;
      quo_d  = dividend_i;
      dsr_d  = divisor_i;
    end else if (busy_q) begin
      if (!diff[W]) begin
        rem_d = diff[W-1:0];
        quo_d = {quo_q[W-2:0], 1'b1};
      end else begin
        rem_d = shifted[W-1:0];
        quo_d = {quo_q[W-2:0], 1'b0};
      end
      cnt_d = cnt_q + smdr_pkg::DIV_CNT_W'(1);
      if (cnt_q == smdr_pkg::DIV_CNT_W'(W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    dsr_q <= dsr_d;
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

[rtl/core/sort_median_decile_ratio.sv]
// ----------------------------------------------------------------------------
// sort_median_decile_ratio
// Loads a set into a RAM kept in descending order by insertion, then reads
// the median and both decile sums and divides them for one result word.
// ----------------------------------------------------------------------------
//  channel | dir | tdata (low bit up)                    | tuser / tlast
//  s_axis  | in  | value[30:0], pad                      | tlast = last
//  m_axis  | out | median_value, decile_ratio, elem_count | tuser = invalid, ovf
//
//  An input word is inserted by stepping down past the values already held:
//  one RAM read and one shift per cycle through a single comparator.
//  The last word then adds the median read, the decile sum reads and the divider.
//  No clearing pass after reset; only RAM entries below the fill count are used.
//  The result sits in an output register; loading of the next set goes on
//  while it waits. s_axis_tready_o is high only between words.
// ----------------------------------------------------------------------------
module sort_median_decile_ratio (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                s_axis_tvalid_i,
  output logic                                s_axis_tready_o,
  input  logic [smdr_pkg::IN_TDATA_W-1:0]     s_axis_tdata_i,  // value[30:0]
  input  logic                                s_axis_tlast_i,  // last
  output logic                                m_axis_tvalid_o,
  input  logic                                m_axis_tready_i,
  // median_value[30:0], decile_ratio[70:31], element_count[79:71]
  output logic [smdr_pkg::OUT_TDATA_W-1:0]    m_axis_tdata_o,
  // ratio_invalid[0], overflowed[1]
  output logic [smdr_pkg::OUT_TUSER_W-1:0]    m_axis_tuser_o
);

  localparam int AW = smdr_pkg::ADDR_W;
  localparam int CW = smdr_pkg::CNT_W;
  localparam int VW = smdr_pkg::VALUE_W;
  localparam int SW = smdr_pkg::SUM_W;

  smdr_pkg::state_e state_q, state_d;

  logic [CW-1:0] cnt_q, cnt_d;
  logic          ovf_q, ovf_d;
  logic          last_q, last_d;
  logic [VW-1:0] key_q, key_d;
  logic [AW-1:0] j_q, j_d;
  logic [CW-1:0] dec_q, dec_d;
  logic [CW-1:0] i_q, i_d;
  logic          side_q, side_d;
  logic [SW-1:0] top_q, top_d;
  logic [SW-1:0] bot_q, bot_d;
  logic [VW-1:0] med_q, med_d;
  logic [smdr_pkg::RATIO_W-1:0] ratio_q, ratio_d;
  logic          inv_q, inv_d;

  logic          out_valid_q, out_valid_d;
  logic [VW-1:0] out_med_q;
  logic [smdr_pkg::RATIO_W-1:0] out_ratio_q;
  logic          out_inv_q;
  logic          out_ovf_q;
  logic [smdr_pkg::COUNT_W-1:0] out_cnt_q;
  logic          out_load;

  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [VW-1:0] ram_wdata;
  logic [AW-1:0] ram_raddr;
  logic [VW-1:0] ram_rdata;

  logic          div_start;
  logic          div_done;
  logic [SW-1:0] div_quo;

  logic [SW-1:0] add_a;
  logic [SW-1:0] add_sum;
  logic [smdr_pkg::PROD_W-1:0] dec_prod;
  logic          s_fire;

  assign s_axis_tready_o = (state_q == smdr_pkg::S_IDLE);
  assign s_fire          = s_axis_tvalid_i && s_axis_tready_o;

  assign add_a    = side_q ? bot_q : top_q;
  assign add_sum  = add_a + SW'(ram_rdata);
  assign dec_prod = smdr_pkg::PROD_W'(cnt_q) * smdr_pkg::PROD_W'(smdr_pkg::DIV10_MUL);

  smdr_ram #(
    .WIDTH(VW),
    .DEPTH(smdr_pkg::MAX_ITEMS)
  ) u_store (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  smdr_div u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (div_start),
    .dividend_i(top_q),
    .divisor_i (bot_q),
    .done_o    (div_done),
    .quotient_o(div_quo)
  );

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    ovf_d       = ovf_q;
    last_d      = last_q;
    key_d       = key_q;
    j_d         = j_q;
    dec_d       = dec_q;
    i_d         = i_q;
    side_d      = side_q;
    top_d       = top_q;
    bot_d       = bot_q;
    med_d       = med_q;
    ratio_d     = ratio_q;
    inv_d       = inv_q;
    out_load    = 1'b0;
    out_valid_d = out_valid_q;
    ram_we      = 1'b0;
    ram_waddr   = j_q;
    ram_wdata   = key_q;
    ram_raddr   = j_q - AW'(2);
    div_start   = 1'b0;

    if (m_axis_tready_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      smdr_pkg::S_IDLE: begin
        ram_raddr = AW'(cnt_q - CW'(1));
        if (s_fire) begin
          last_d = s_axis_tlast_i;
          if (cnt_q < CW'(smdr_pkg::MAX_ITEMS)) begin
            key_d   = s_axis_tdata_i[VW-1:0];
            j_d     = AW'(cnt_q);
            state_d = smdr_pkg::S_INS;
          end else begin
            ovf_d = 1'b1;
            if (s_axis_tlast_i) begin
              state_d = smdr_pkg::S_MED;
            end
          end
        end
      end
      smdr_pkg::S_INS: begin
        ram_we = 1'b1;
        if (j_q != '0 && ram_rdata < key_q) begin
          ram_wdata = ram_rdata;
          j_d       = j_q - AW'(1);
        end else begin
          ram_wdata = key_q;
          cnt_d     = cnt_q + CW'(1);
          state_d   = last_q ? smdr_pkg::S_MED : smdr_pkg::S_IDLE;
        end
      end
      smdr_pkg::S_MED: begin
        ram_raddr = AW'(cnt_q >> 1);
        dec_d     = CW'(dec_prod >> smdr_pkg::DIV10_SHIFT);
        top_d     = '0;
        bot_d     = '0;
        i_d       = '0;
        side_d    = 1'b0;
        state_d   = smdr_pkg::S_MEDW;
      end
      smdr_pkg::S_MEDW: begin
        med_d     = ram_rdata;
        ram_raddr = '0;
        state_d   = (dec_q == '0) ? smdr_pkg::S_DIV : smdr_pkg::S_SUM;
      end
      smdr_pkg::S_SUM: begin
        if (side_q) begin
          bot_d     = add_sum;
          side_d    = 1'b0;
          i_d       = i_q + CW'(1);
          ram_raddr = AW'(i_q + CW'(1));
          if (i_q + CW'(1) == dec_q) begin
            state_d = smdr_pkg::S_DIV;
          end
        end else begin
          top_d     = add_sum;
          side_d    = 1'b1;
          ram_raddr = AW'(cnt_q - CW'(1) - i_q);
        end
      end
      smdr_pkg::S_DIV: begin
        if (bot_q == '0) begin
          ratio_d = '0;
          inv_d   = 1'b1;
          state_d = smdr_pkg::S_DONE;
        end else begin
          div_start = 1'b1;
          inv_d     = 1'b0;
          state_d   = smdr_pkg::S_DIVW;
        end
      end
      smdr_pkg::S_DIVW: begin
        if (div_done) begin
          ratio_d = smdr_pkg::RATIO_W'(div_quo);
          state_d = smdr_pkg::S_DONE;
        end
      end
      smdr_pkg::S_DONE: begin
        if (!out_valid_q || m_axis_tready_i) begin
          out_load    = 1'b1;
          out_valid_d = 1'b1;
          cnt_d       = '0;
          ovf_d       = 1'b0;
          state_d     = smdr_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = smdr_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= smdr_pkg::S_IDLE;
      cnt_q       <= '0;
      ovf_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      ovf_q       <= ovf_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    last_q  <= last_d;
    key_q   <= key_d;
    j_q     <= j_d;
    dec_q   <= dec_d;
    i_q     <= i_d;
    side_q  <= side_d;
    top_q   <= top_d;
    bot_q   <= bot_d;
    med_q   <= med_d;
    ratio_q <= ratio_d;
    inv_q   <= inv_d;
    if (out_load) begin
      out_med_q   <= med_q;
      out_ratio_q <= ratio_q;
      out_inv_q   <= inv_q;
      out_ovf_q   <= ovf_q;
      out_cnt_q   <= smdr_pkg::COUNT_W'(cnt_q);
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = smdr_pkg::OUT_TDATA_W'({out_cnt_q, out_ratio_q, out_med_q});
  assign m_axis_tuser_o  = {out_ovf_q, out_inv_q};

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CW'(smdr_pkg::MAX_ITEMS))
    else $error("fill count above capacity");

  a_ins_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == smdr_pkg::S_INS |-> CW'(j_q) <= cnt_q)
    else $error("insert position beyond fill count");

  a_load_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |=> cnt_q == '0 && !ovf_q && out_valid_q)
    else $error("set state not cleared after result load");

  a_div_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_start |-> bot_q != '0)
    else $error("divider started with zero divisor");

  a_inv_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && out_inv_q |-> out_ratio_q == '0)
    else $error("invalid ratio not forced to zero");

endmodule

[tb/sort_median_decile_ratio_tb.sv]
// ----------------------------------------------------------------------------
// sort_median_decile_ratio_tb
// Streams value sets into the median and decile ratio block. A directed part
// covers single-word sets, value extremes, small sets and zero bottom sums.
// Random sets of mixed size and content follow, with one full set and one
// set that overflows. Every accepted word updates a local model of the
// block, and every result word is checked field by field against it. The
// sender idles in random bursts and the receiver stalls on its own pattern.
// ----------------------------------------------------------------------------
module sort_median_decile_ratio_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int GAP_MAX      = 12;
  localparam int STALL_MAX    = 20;
  localparam int READY_MAX    = 40;
  localparam int TAIL_CYCLES  = 400;
  localparam int RANDOM_WORDS = 1700;

  localparam int VALUE_W     = smdr_pkg::VALUE_W;
  localparam int RATIO_W     = smdr_pkg::RATIO_W;
  localparam int COUNT_W     = smdr_pkg::COUNT_W;
  localparam int MAX_ITEMS   = smdr_pkg::MAX_ITEMS;
  localparam int SUM_W       = smdr_pkg::SUM_W;
  localparam int IN_TDATA_W  = smdr_pkg::IN_TDATA_W;
  localparam int OUT_TDATA_W = smdr_pkg::OUT_TDATA_W;
  localparam int OUT_TUSER_W = smdr_pkg::OUT_TUSER_W;

  typedef bit [VALUE_W-1:0] value_t;

  typedef struct {
    value_t value;
    bit     last;
  } set_word_t;

  typedef struct {
    value_t             median;
    bit [RATIO_W-1:0]   ratio;
    bit                 invalid;
    bit                 ovf;
    bit [COUNT_W-1:0]   count;
  } set_stats_t;

  localparam value_t VALUE_MAX = '1;

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   s_tvalid = 1'b0;
  logic                   s_tready;
  logic [IN_TDATA_W-1:0]  s_tdata = '0;   // value[30:0], pad
  logic                   s_tlast = 1'b0; // last
  logic                   m_tvalid;
  logic                   m_tready = 1'b0;
  // median_value[30:0], decile_ratio[70:31], element_count[79:71]
  logic [OUT_TDATA_W-1:0] m_tdata;
  // ratio_invalid[0], overflowed[1]
  logic [OUT_TUSER_W-1:0] m_tuser;

  set_word_t  word_queue[$];
  set_stats_t expected_stats[$];
  value_t     open_set[$];
  bit         open_ovf = 1'b0;

  set_word_t  next_word;
  int         burst_left = 0;
  int         gap_left = 0;
  int         ready_hold = 0;
  int         error_count = 0;
  int         word_total = 0;
  int         plan_held = 0;
  longint     plan_budget = 0;
  longint     cycle_limit = 64'd100_000_000;
  longint     cycle_count = 0;

  sort_median_decile_ratio dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tlast_i  (s_tlast),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata),
    .m_axis_tuser_o  (m_tuser)
  );

  always #5 clk_i = ~clk_i;

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    if (error_count < 50) begin
      $display("%0t mismatch %s: got %0h want %0h", $realtime, what, got, want);
    end
    error_count++;
  endtask

  task automatic tally_word(input value_t value, input bit last);
    value_t     ranked[$];
    value_t     key;
    int         n;
    int         d;
    int         j;
    bit [63:0]  top_sum;
    bit [63:0]  bot_sum;
    set_stats_t stats;
    if (open_set.size() < MAX_ITEMS) begin
      open_set.push_back(value);
    end else begin
      open_ovf = 1'b1;
    end
    if (last) begin
      ranked = open_set;
      n = ranked.size();
      for (int i = 1; i < n; i++) begin
        key = ranked[i];
        j = i;
        while (j > 0 && ranked[j-1] < key) begin
          ranked[j] = ranked[j-1];
          j--;
        end
        ranked[j] = key;
      end
      d = n / 10;
      top_sum = '0;
      bot_sum = '0;
      for (int i = 0; i < d; i++) begin
        top_sum += 64'(ranked[i]);
        bot_sum += 64'(ranked[n-1-i]);
      end
      stats.median  = ranked[n/2];
      stats.invalid = (bot_sum == '0);
      stats.ratio   = stats.invalid ? '0 : RATIO_W'(top_sum / bot_sum);
      stats.ovf     = open_ovf;
      stats.count   = COUNT_W'(n);
      expected_stats.push_back(stats);
      open_set.delete();
      open_ovf = 1'b0;
    end
  endtask

  task automatic check_result();
    set_stats_t want;
    if (expected_stats.size() == 0) begin
      report_mismatch("result with none pending", 64'(m_tdata[VALUE_W-1:0]), '0);
    end else begin
      want = expected_stats.pop_front();
      if (m_tdata[VALUE_W-1:0] != want.median)
        report_mismatch("median_value", 64'(m_tdata[VALUE_W-1:0]), 64'(want.median));
      if (m_tdata[VALUE_W +: RATIO_W] != want.ratio)
        report_mismatch("decile_ratio", 64'(m_tdata[VALUE_W +: RATIO_W]),
                        64'(want.ratio));
      if (m_tdata[VALUE_W+RATIO_W +: COUNT_W] != want.count)
        report_mismatch("element_count", 64'(m_tdata[VALUE_W+RATIO_W +: COUNT_W]),
                        64'(want.count));
      if (m_tuser[0] != want.invalid)
        report_mismatch("ratio_invalid", 64'(m_tuser[0]), 64'(want.invalid));
      if (m_tuser[1] != want.ovf)
        report_mismatch("overflowed", 64'(m_tuser[1]), 64'(want.ovf));
    end
  endtask

  // sender: bursts of words with random gaps
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_tvalid   <= 1'b0;
      s_tdata    <= '0;
      s_tlast    <= 1'b0;
      burst_left <= 0;
      gap_left   <= 0;
    end else begin
      if (s_tvalid && s_tready) begin
        tally_word(s_tdata[VALUE_W-1:0], s_tlast);
      end
      if (!s_tvalid || s_tready) begin
        if (gap_left != 0 || word_queue.size() == 0) begin
          s_tvalid <= 1'b0;
          if (gap_left != 0) gap_left <= gap_left - 1;
        end else begin
          next_word = word_queue.pop_front();
          s_tvalid <= 1'b1;
          s_tdata  <= {{(IN_TDATA_W-VALUE_W){1'b0}}, next_word.value};
          s_tlast  <= next_word.last;
          if (burst_left <= 1) begin
            burst_left <= $urandom_range(1, 24);
            gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, GAP_MAX);
          end else begin
            burst_left <= burst_left - 1;
          end
        end
      end
    end
  end

  // receiver: alternate ready windows and stalls
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_tready   <= 1'b0;
      ready_hold <= 0;
    end else begin
      if (m_tvalid && m_tready) check_result();
      if (ready_hold != 0) begin
        ready_hold <= ready_hold - 1;
      end else begin
        m_tready   <= !m_tready;
        ready_hold <= m_tready ? $urandom_range(0, STALL_MAX - 1)
                               : $urandom_range(0, READY_MAX);
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > cycle_limit) begin
      $display("sort_median_decile_ratio_tb: errors");
      $finish;
    end
  end

  function automatic value_t pick_value(input int style);
    case (style)
      0: return value_t'($urandom());
      1: return value_t'($urandom_range(0, 3));
      2: begin
        case ($urandom_range(0, 3))
          0: return '0;
          1: return value_t'(1);
          2: return VALUE_MAX;
          default: return VALUE_MAX - 1;
        endcase
      end
      default: return value_t'($urandom_range(0, 1000));
    endcase
  endfunction

  task automatic add_word(input value_t value, input bit last);
    set_word_t w;
    w.value = value;
    w.last  = last;
    word_queue.push_back(w);
    word_total++;
    plan_budget += plan_held + 3 + GAP_MAX;
    if (plan_held < MAX_ITEMS) plan_held++;
    if (last) begin
      plan_budget += 2 * (plan_held / 10) + SUM_W + 6 + STALL_MAX + READY_MAX;
      plan_held = 0;
    end
  endtask

  task automatic add_set(input int n, input int style);
    for (int i = 0; i < n; i++) add_word(pick_value(style), i == n - 1);
  endtask

  initial begin
    int n;
    int kind;
    bit full_done;
    bit ovf_done;
    full_done = 1'b0;
    ovf_done  = 1'b0;

    // single-word sets at both extremes
    add_word(VALUE_MAX, 1'b1);
    add_word('0, 1'b1);
    // small set, median in the middle
    add_word(value_t'(5), 1'b0);
    add_word(VALUE_MAX, 1'b0);
    add_word('0, 1'b1);
    // ten words: top decile max, bottom decile one
    add_word(VALUE_MAX, 1'b0);
    for (int i = 3; i <= 10; i++) add_word(value_t'(i), 1'b0);
    add_word(value_t'(1), 1'b1);
    // ten words with a zero bottom decile
    add_word('0, 1'b0);
    for (int i = 0; i < 8; i++) add_word(pick_value(0), 1'b0);
    add_word(VALUE_MAX, 1'b1);

    while (word_total < RANDOM_WORDS) begin
      if (!full_done && word_total > 400) begin
        add_set(MAX_ITEMS, 0);
        full_done = 1'b1;
      end else if (!ovf_done && word_total > 1000) begin
        add_set(MAX_ITEMS + $urandom_range(1, 6), 3);
        ovf_done = 1'b1;
      end else begin
        kind = $urandom_range(0, 99);
        if (kind < 75) begin
          n = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 9) : $urandom_range(10, 40);
          add_set(n, $urandom_range(0, 3));
        end else if (kind < 90) begin
          // force zeros into the bottom decile
          n = $urandom_range(10, 30);
          for (int i = 0; i < n; i++) begin
            add_word((i < n / 10) ? value_t'(0) : pick_value(0), i == n - 1);
          end
        end else begin
          add_set($urandom_range(1, 60), 2);
        end
      end
    end
    cycle_limit = 4 * plan_budget + 1000;

    repeat (9) @(posedge clk_i);
    @(negedge clk_i) rst_ni = 1'b1;

    while (word_queue.size() != 0 || s_tvalid || expected_stats.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (TAIL_CYCLES) @(posedge clk_i);

    if (error_count == 0) begin
      $display("sort_median_decile_ratio_tb: clean");
    end else begin
      $display("sort_median_decile_ratio_tb: errors");
    end
    $finish;
  end

endmodule
